@@ src/all_pairs_hop_distance_defines.svh @@
// Assertion macros for the all-pairs hop distance block.
`ifndef ALL_PAIRS_HOP_DISTANCE_DEFINES_SVH
`define ALL_PAIRS_HOP_DISTANCE_DEFINES_SVH
`ifndef ASSERT_OFF
`define APHD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("lbl");
`define APHD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("lbl");
`else
`define APHD_ASSERT(lbl, prop)
`define APHD_ASSERT_RST(lbl, prop)
`endif
`endif

@@ src/aphd_pkg.sv @@
// Package with types and constants of the all-pairs hop distance block.
package aphd_pkg;
  localparam int unsigned NumV = 16;
  localparam int unsigned VW = $clog2(NumV);
  localparam int unsigned DW = 5;
  localparam logic [DW-1:0] DistInf = '1;
  localparam logic [1:0] RegVertexCount = 2'd0;

  typedef enum logic [1:0] {
    ReqLoad  = 2'd0,
    ReqRun   = 2'd1,
    ReqQuery = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StIdle,
    StInit,
    StRelax,
    StDone
  } state_e;

  typedef struct packed {
    logic          init;
    logic          shift;
    logic [VW-1:0] k;
    logic [VW-1:0] i;
    logic [VW:0]   n;
  } cell_ctl_t;
endpackage

@@ src/all_pairs_hop_distance.sv @@
// Top level of the all-pairs hop distance block with control and cell array.
// Loads and queries are accepted one per cycle while idle, and a query answers in the cycle
// after it is accepted. A run keeps the input stalled until its done item is issued, whatever
// the configured count: the init state seeds the table, then one relax step per source row i
// and intermediate vertex k with all cells of the row updating in parallel, then the done
// state issues the done item. A stalled result holds the input for as long as it waits.
`include "all_pairs_hop_distance_defines.svh"
module all_pairs_hop_distance
  import aphd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    req_type_i,
  input  logic [3:0]    row_index_i,
  input  logic [15:0]   adj_row_i,
  input  logic [3:0]    src_vertex_i,
  input  logic [3:0]    dst_vertex_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          result_kind_o,
  output logic [3:0]    hop_distance_o,
  output logic          reachable_o
);
  logic [4:0]    vcnt_q;
  logic [NumV-1:0] adj_q [NumV];
  state_e        st_q, st_d;
  logic [VW-1:0] k_q, k_d, i_q, i_d;
  logic          ov_q, ov_d, kind_q, kind_d, reach_q, reach_d;
  logic [3:0]    hd_q, hd_d;
  logic          acc, ofree;
  cell_ctl_t     ctl;
  logic [DW-1:0] cell_dist [NumV*NumV];
  logic [VW:0]   n;

  assign pready = 1'b1;
  assign prdata = (paddr == RegVertexCount) ? {27'd0, vcnt_q} : 32'd0;
  assign n = (vcnt_q > 5'(NumV)) ? (VW+1)'(NumV) : vcnt_q[VW:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= 5'd16;
    end else if (psel && penable && pwrite && paddr == RegVertexCount) begin
      vcnt_q <= pwdata[4:0];
    end
  end

  assign ofree = !ov_q || !out_stall_i;
  assign in_stall_o = (st_q != StIdle) || !ofree;
  assign acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumV; r++) adj_q[r] <= '0;
    end else if (acc && req_type_i == ReqLoad) begin
      adj_q[row_index_i] <= adj_row_i;
    end
  end

  assign ctl.init = (st_q == StInit);
  assign ctl.shift = (st_q == StRelax);
  assign ctl.k = k_q;
  assign ctl.i = i_q;
  assign ctl.n = n;

  // Each cell holds one table entry; in a relax step the cells of row i take the path
  // through vertex k.
  for (genvar g = 0; g < NumV*NumV; g++) begin : g_cell
    localparam int R = g / NumV;
    localparam int C = g % NumV;
    aphd_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .row_i (VW'(R)),
      .col_i (VW'(C)),
      .adj_i (adj_q[R][C]),
      .ik_i  (cell_dist[{VW'(R), k_q}]),
      .kj_i  (cell_dist[{k_q, VW'(C)}]),
      .prev_i(cell_dist[g]),
      .dist_o(cell_dist[g])
    );
  end

  always_comb begin
    logic [DW-1:0] e;
    e = cell_dist[{src_vertex_i, dst_vertex_i}];
    st_d = st_q; k_d = k_q; i_d = i_q;
    ov_d = ov_q && out_stall_i;
    kind_d = kind_q; hd_d = hd_q; reach_d = reach_q;
    case (st_q)
      StIdle: begin
        if (acc && req_type_i == ReqRun) begin
          st_d = StInit;
        end else if (acc && req_type_i == ReqQuery) begin
          ov_d = 1'b1; kind_d = 1'b1; hd_d = '0; reach_d = 1'b0;
          if ({1'b0, src_vertex_i} < n && {1'b0, dst_vertex_i} < n && e != DistInf) begin
            reach_d = 1'b1;
            hd_d = e[3:0];
          end
        end
      end
      StInit: begin
        k_d = '0; i_d = '0; st_d = StRelax;
      end
      StRelax: begin
        i_d = i_q + 1'b1;
        if (i_q == '1) begin
          k_d = k_q + 1'b1;
          if (k_q == '1) st_d = StDone;
        end
      end
      StDone: begin
        if (ofree) begin
          ov_d = 1'b1; kind_d = 1'b0; hd_d = '0; reach_d = 1'b0;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; k_q <= '0; i_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; k_q <= k_d; i_q <= i_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; hd_q <= hd_d; reach_q <= reach_d;
  end

  assign out_valid_o = ov_q;
  assign result_kind_o = kind_q;
  assign hop_distance_o = hd_q;
  assign reachable_o = reach_q;

  `APHD_ASSERT(a_busy_stall, (st_q != StIdle) |-> in_stall_o)
  `APHD_ASSERT(a_done_kind, (ov_q && !kind_q) |-> !reach_q && hd_q == 4'd0)
  `APHD_ASSERT(a_out_hold, (ov_q && out_stall_i) |=> ov_q && $stable(hd_q))
endmodule

@@ src/aphd_cell.sv @@
// One cell of the relaxation array: holds one distance entry of the table.
module aphd_cell
  import aphd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic [VW-1:0]   row_i,
  input  logic [VW-1:0]   col_i,
  input  logic            adj_i,
  input  logic [DW-1:0]   ik_i,
  input  logic [DW-1:0]   kj_i,
  input  logic [DW-1:0]   prev_i,
  output logic [DW-1:0]   dist_o
);
  logic [DW-1:0] dist_q, dist_d;
  logic [DW:0]   cand;
  logic          in_cnt;

  assign in_cnt = ({1'b0, row_i} < ctl_i.n) && ({1'b0, col_i} < ctl_i.n);
  assign cand = {1'b0, ik_i} + {1'b0, kj_i};

  always_comb begin
    dist_d = dist_q;
    if (ctl_i.init) begin
      if (!in_cnt) begin
        dist_d = DistInf;
      end else if (row_i == col_i) begin
        dist_d = '0;
      end else if (adj_i) begin
        dist_d = DW'(1);
      end else begin
        dist_d = DistInf;
      end
    end else if (ctl_i.shift) begin
      dist_d = prev_i;
      if (row_i == ctl_i.i && ik_i != DistInf && kj_i != DistInf && in_cnt &&
          (prev_i == DistInf || cand < {1'b0, prev_i})) begin
        dist_d = cand[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= DistInf;
    end else begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;
endmodule

@@ tb/all_pairs_hop_distance_tb.sv @@
// Self-checking testbench for the all-pairs hop distance block.
module all_pairs_hop_distance_tb;
  import aphd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [3:0]  row_index_i = '0;
  logic [15:0] adj_row_i = '0;
  logic [3:0]  src_vertex_i = '0;
  logic [3:0]  dst_vertex_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [3:0]  hop_distance_o;
  logic        reachable_o;

  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic       kind;
    logic [3:0] hops;
    logic       reach;
  } answer_t;

  answer_t     answers_due[$];
  logic [15:0] graph_rows[NumV];
  logic [4:0]  hop_table[NumV][NumV];
  logic        hop_known[NumV][NumV];
  logic [4:0]  vertex_count;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          timed_out = 1'b0;

  all_pairs_hop_distance uut (.*);

  always #10 clk_i = ~clk_i;

  function automatic int unsigned active_count();
    return (vertex_count > NumV) ? NumV : vertex_count;
  endfunction

  function automatic void rebuild_distances();
    int unsigned n;
    logic [4:0] cand;
    n = active_count();
    for (int i = 0; i < NumV; i++)
      for (int j = 0; j < NumV; j++) begin
        hop_known[i][j] = 1'b0;
        hop_table[i][j] = '0;
        if (i < n && j < n) begin
          if (i == j) begin
            hop_known[i][j] = 1'b1;
          end else if (graph_rows[i][j]) begin
            hop_known[i][j] = 1'b1;
            hop_table[i][j] = 5'd1;
          end
        end
      end
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        if (hop_known[i][k])
          for (int j = 0; j < n; j++)
            if (hop_known[k][j]) begin
              cand = hop_table[i][k] + hop_table[k][j];
              if (!hop_known[i][j] || cand < hop_table[i][j]) begin
                hop_known[i][j] = 1'b1;
                hop_table[i][j] = cand;
              end
            end
  endfunction

  function automatic void predict_request(req_e req, logic [3:0] row, logic [15:0] bits,
                                          logic [3:0] src, logic [3:0] dst);
    answer_t a;
    a = '0;
    case (req)
      ReqLoad: begin
        graph_rows[row] = bits;
      end
      ReqRun: begin
        rebuild_distances();
        answers_due.insert(answers_due.size(), a);
      end
      ReqQuery: begin
        a.kind = 1'b1;
        if (src < active_count() && dst < active_count() && hop_known[src][dst]) begin
          a.reach = 1'b1;
          a.hops = (hop_table[src][dst] > 15) ? 4'd15 : hop_table[src][dst][3:0];
        end
        answers_due.insert(answers_due.size(), a);
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(req_e req, logic [3:0] row, logic [15:0] bits,
                              logic [3:0] src, logic [3:0] dst);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    row_index_i <= row;
    adj_row_i <= bits;
    src_vertex_i <= src;
    dst_vertex_i <= dst;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(req, row, bits, src, dst);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (answers_due.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(logic [4:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegVertexCount;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    vertex_count = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_graph(int density);
    for (int r = 0; r < NumV; r++) begin
      logic [15:0] bits;
      bits = '0;
      for (int b = 0; b < 16; b++) bits[b] = ($urandom_range(99) < density);
      send_request(ReqLoad, 4'(r), bits, 4'($urandom), 4'($urandom));
    end
  endtask

  task automatic test_directed();
    send_request(ReqQuery, 4'd0, '0, 4'd0, 4'd15);
    send_request(ReqQuery, 4'd0, '0, 4'd3, 4'd3);
    send_request(ReqNone, 4'd5, 16'hffff, 4'd1, 4'd2);
    for (int r = 0; r < 15; r++)
      send_request(ReqLoad, 4'(r), 16'(1 << (r + 1)) | 16'(1 << r), 4'hf, 4'hf);
    send_request(ReqLoad, 4'd15, 16'hffff, 4'd0, 4'd0);
    send_request(ReqRun, 4'd0, '0, 4'd0, 4'd0);
    send_request(ReqQuery, 4'd0, '0, 4'd0, 4'd15);
    send_request(ReqQuery, 4'd0, '0, 4'd15, 4'd0);
    send_request(ReqQuery, 4'd0, '0, 4'd7, 4'd7);
    send_request(ReqQuery, 4'd0, '0, 4'd9, 4'd2);
    drain();
  endtask

  task automatic test_counts();
    logic [4:0] counts[6] = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd7, 5'd17};
    foreach (counts[c]) begin
      write_vertex_count(counts[c]);
      random_graph(20);
      send_request(ReqRun, 4'd0, '0, 4'd0, 4'd0);
      repeat (10) send_request(ReqQuery, 4'd0, '0, 4'($urandom), 4'($urandom));
      drain();
    end
    write_vertex_count(5'd16);
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int t = 0; t < count; t++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) random_graph($urandom_range(5, 30));
      else if (pick < 15) send_request(ReqRun, 4'($urandom), 16'($urandom), 4'd0, 4'd0);
      else if (pick < 17) send_request(ReqNone, 4'($urandom), 16'($urandom),
                                       4'($urandom), 4'($urandom));
      else if (pick < 25) send_request(ReqLoad, 4'($urandom), 16'($urandom),
                                       4'($urandom), 4'($urandom));
      else send_request(ReqQuery, 4'($urandom), 16'($urandom), 4'($urandom), 4'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 400;
    repeat (40) send_request(ReqQuery, 4'd0, '0, 4'($urandom), 4'($urandom));
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    answer_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{result_kind_o, hop_distance_o, reachable_o};
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        if (got !== answers_due[0]) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", answers_due[0], got);
        end
        void'(answers_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    vertex_count = 5'd16;
    for (int r = 0; r < NumV; r++) graph_rows[r] = '0;
    for (int i = 0; i < NumV; i++)
      for (int j = 0; j < NumV; j++) begin
        hop_known[i][j] = 1'b0;
        hop_table[i][j] = '0;
      end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_counts();
    test_random(100, 12, 50);
    test_random(100, 50, 12);
    test_backpressure();
    test_random(100, 0, 0);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
